// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Request action codes
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Character codes with special handling
   localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [7:0] CODE_BACKSPACE = 8'h08;
   localparam logic [7:0] CODE_SPACE     = 8'h20;

   // Attribute after reset, and the blank cell the store holds after reset
   localparam logic [7:0]  ATTR_RESET  = 8'h0F;
   localparam logic [15:0] RESET_BLANK = {ATTR_RESET, CODE_SPACE};

   // Field widths
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int RROW_W   = 5;
   localparam int RCOL_W   = 7;
   localparam int CELL_W   = 16;

   // Register port
   localparam int              CSR_ADDR_W    = 3;
   localparam int              CSR_DATA_W    = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTR_ADDR = 3'd0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_SCROLL,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/text_console_writer_top.sv =====
// Top level of the text console writer: screen store, cursor and sequencer.
`timescale 1ns / 1ps

// Text console writer.
// Request channel: a request is taken at a rising edge with start high and
// busy low. Fields: action (put / clear / read), char_code, read_row/col.
// Response channel: exactly one response per request, shown for one cycle
// with rsp_strobe high; the receiver cannot stall it, so none is held.
// Sequence per request (memory has a registered read port, one write port):
//   put (normal char, newline, backspace without scroll): response in the
//     cycle after acceptance, busy stays low, so one request per cycle.
//   read in range: the memory read is registered, then ST_READ_WAIT registers the response.
//   read out of range / unused action: answered like a put, cell_value 0.
//   clear: one cell written per cycle over all ROWS*COLUMNS cells; cursor homes.
//   put that scrolls: the copy walk reads cell i+COLUMNS and writes cell i
//     from the read data in the cycle after, then blanks the last row.
// Reset: cursor homes, attribute goes to 0x0F, and a clearing pass writes
//   blank 0x0F20 into all ROWS*COLUMNS cells, one per cycle; busy is high
//   for those cycles. Register writes are taken during the pass.
// Register port: APB style, text_attribute at byte address 0, pready high.
module text_console_writer_top import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [RROW_W-1:0]     req_read_row,
   input  logic [RCOL_W-1:0]     req_read_col,
   // response channel
   output logic                  rsp_strobe,
   output logic [CELL_W-1:0]     rsp_cell_value,
   output logic [RROW_W-1:0]     rsp_row_now,
   output logic [RCOL_W-1:0]     rsp_col_now,
   output logic                  rsp_did_scroll,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int TOTAL  = ROWS * COLUMNS;
   localparam int COPY_N = (ROWS - 1) * COLUMNS;   // cells moved up on scroll
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
   localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(COPY_N);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

   // ------------------------------------------------------------------
   // Register block
   // ------------------------------------------------------------------
   logic [7:0] text_attribute;

   tcw_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .text_attribute (text_attribute)
   );

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [ROW_W-1:0]    pos_row_ff, pos_row_in;
   logic [COL_W-1:0]    pos_col_ff, pos_col_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;          // sweep position

   // scroll write stage: registered behind the copy read
   logic                stg_vld_ff, stg_vld_in;
   logic [ADDR_W-1:0]   stg_addr_ff, stg_addr_in;
   logic                stg_mem_ff, stg_mem_in;  // 1: copy read data, 0: blank

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic                rsp_scroll_ff, rsp_scroll_in;

   // screen store
   logic [CELL_W-1:0]   mem [TOTAL];
   logic [CELL_W-1:0]   mem_rdata_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [CELL_W-1:0]   mem_wdata;

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic                accept;
   logic                is_newline, is_backspace, on_last_row, on_last_col;
   logic                scroll_needed, read_in_range, sweep_last;
   logic [CELL_W-1:0]   blank_cell;
   logic [ADDR_W-1:0]   cursor_addr, left_addr, read_addr;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign is_newline    = (req_char_code == CODE_NEWLINE);
   assign is_backspace  = (req_char_code == CODE_BACKSPACE);
   assign on_last_row   = (pos_row_ff == LAST_ROW);
   assign on_last_col   = (pos_col_ff == LAST_COL);
   // newline, or a printable char in the last column, on the bottom row
   assign scroll_needed = on_last_row && (is_newline || (!is_backspace && on_last_col));
   assign read_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
   assign sweep_last    = (cnt_ff == LAST_ADDR);
   assign blank_cell    = {text_attribute, CODE_SPACE};

   assign cursor_addr = ADDR_W'(32'(pos_row_ff) * COLUMNS + 32'(pos_col_ff));
   assign left_addr   = ADDR_W'(32'(pos_row_ff) * COLUMNS + 32'(pos_col_ff) - 32'd1);
   assign read_addr   = ADDR_W'(32'(req_read_row) * COLUMNS + 32'(req_read_col));

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_PUT:   if (scroll_needed) state_in = ST_SCROLL;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_READ:  if (read_in_range) state_in = ST_READ_WAIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_CLEAR: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_INIT;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath, memory ports and response
   // ------------------------------------------------------------------
   always_comb begin
      pos_row_in    = pos_row_ff;
      pos_col_in    = pos_col_ff;
      cnt_in        = cnt_ff;
      stg_vld_in    = 1'b0;
      stg_addr_in   = cnt_ff;
      stg_mem_in    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_cell_in   = '0;
      rsp_scroll_in = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cursor_addr;
      mem_wdata     = blank_cell;
      mem_re        = 1'b0;
      mem_raddr     = read_addr;

      // stage write owns the port during scroll; nothing else writes then
      if (stg_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = stg_addr_ff;
         mem_wdata = stg_mem_ff ? mem_rdata_ff : blank_cell;
      end

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = RESET_BLANK;
            cnt_in    = sweep_last ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               // immediate response unless a sweep or a read follows
               rsp_strobe_in = (state_in == ST_IDLE);
               cnt_in        = '0;
               case (req_action)
                  ACT_PUT: begin
                     if (is_newline) begin
                        pos_col_in = '0;
                        if (!on_last_row) pos_row_in = pos_row_ff + 1'b1;
                     end else if (is_backspace) begin
                        if (pos_col_ff != '0) begin
                           pos_col_in = pos_col_ff - 1'b1;
                           mem_we     = 1'b1;
                           mem_waddr  = left_addr;
                           mem_wdata  = blank_cell;
                        end
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_addr;
                        mem_wdata = {text_attribute, req_char_code};
                        if (on_last_col) begin
                           pos_col_in = '0;
                           if (!on_last_row) pos_row_in = pos_row_ff + 1'b1;
                        end else begin
                           pos_col_in = pos_col_ff + 1'b1;
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     pos_row_in = '0;
                     pos_col_in = '0;
                  end
                  ACT_READ: begin
                     mem_re    = read_in_range;
                     mem_raddr = read_addr;
                  end
                  default: begin
                     pos_row_in = pos_row_ff;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_cell_in   = mem_rdata_ff;
         end
         ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = cnt_ff;
            mem_wdata     = blank_cell;
            cnt_in        = sweep_last ? '0 : cnt_ff + 1'b1;
            rsp_strobe_in = sweep_last;
         end
         ST_SCROLL: begin
            // cells before the last row start are copied from one row down,
            // the last row is blanked
            stg_vld_in  = 1'b1;
            stg_addr_in = cnt_ff;
            if (cnt_ff < LAST_COPY) begin
               mem_re     = 1'b1;
               mem_raddr  = ADDR_W'(32'(cnt_ff) + COLUMNS);
               stg_mem_in = 1'b1;
            end
            cnt_in = sweep_last ? '0 : cnt_ff + 1'b1;
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_scroll_in = 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pos_row_ff    <= '0;
         pos_col_ff    <= '0;
         cnt_ff        <= '0;
         stg_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_row_ff    <= pos_row_in;
         pos_col_ff    <= pos_col_in;
         cnt_ff        <= cnt_in;
         stg_vld_ff    <= stg_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_addr_ff   <= stg_addr_in;
      stg_mem_ff    <= stg_mem_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   // screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Response ports; cursor shows its value after the request
   // ------------------------------------------------------------------
   logic [31:0] row_ext, col_ext;

   assign row_ext        = 32'(pos_row_ff);
   assign col_ext        = 32'(pos_col_ff);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_row_now    = row_ext[RROW_W-1:0];
   assign rsp_col_now    = col_ext[RCOL_W-1:0];
   assign rsp_did_scroll = rsp_scroll_ff;

`ifndef SYNTHESIS
   // every request either responds next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("request neither answered nor in progress");

   // no read and write hit the same cell in the same cycle, copy walk included
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write to the same cell");

   // cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(pos_row_ff) < ROWS) && (32'(pos_col_ff) < COLUMNS))
      else $error("cursor off screen");

   // a scroll response leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_did_scroll |-> (rsp_strobe && pos_col_ff == '0 && on_last_row))
      else $error("scroll response with cursor misplaced");
`endif

endmodule

// ===== hdl/tcw_csr.sv =====
// Register block of the text console writer: the text attribute register.
`timescale 1ns / 1ps

module tcw_csr import tcw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [7:0]            text_attribute
);

   logic [7:0] attr_ff;
   logic [7:0] attr_in;
   logic       hit_attr;

   // word decode; byte offset within the word is ignored
   assign hit_attr = (paddr[CSR_ADDR_W-1:2] == CSR_ATTR_ADDR[CSR_ADDR_W-1:2]);

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && hit_attr) begin
         attr_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign prdata         = hit_attr ? {{(CSR_DATA_W-8){1'b0}}, attr_ff} : '0;
   assign pready         = 1'b1;
   assign text_attribute = attr_ff;

endmodule
